FILE: hw/rtl/shp3_pkg.sv
// Shared types, constants and the channel arithmetic of the 3x3 sharpen filter.
`default_nettype none
package shp3_pkg;

    // Fixed field widths
    localparam int CHAN_W       = 8;
    localparam int ROW_W        = 16;
    localparam int ANCHOR_COL_W = 11;
    localparam int FW_REG_W     = 12;
    localparam int FH_REG_W     = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [FW_REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_REG_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    // Filter constants
    localparam int MIN_DIM     = 3;
    localparam int WIN_OFFSET  = 2;
    localparam int CENTER_GAIN = 5;
    localparam int CHAN_MAX    = 255;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    // One line store entry: the pixel two rows up and the pixel one row up
    typedef struct packed {
        pix_t top;
        pix_t mid;
    } line_pair_t;

    // Per-word control carried from the counter stage to the window stage
    typedef struct packed {
        logic                    emit;
        logic                    last;
        logic [ROW_W-1:0]        row;
        logic [ANCHOR_COL_W-1:0] col;
    } ctrl_t;

    // CENTER_GAIN * centre minus the edge neighbours, clamped to 0..255
    function automatic logic [CHAN_W-1:0] sharpen_chan(
        input logic [CHAN_W-1:0] center,
        input logic [CHAN_W-1:0] up,
        input logic [CHAN_W-1:0] down,
        input logic [CHAN_W-1:0] left,
        input logic [CHAN_W-1:0] right
    );
        logic [10:0] pos;
        logic [9:0]  neg;
        logic [10:0] diff;
        logic [CHAN_W-1:0] res;
        pos  = {3'b000, center} * 11'(CENTER_GAIN);
        neg  = {2'b00, up} + {2'b00, down} + {2'b00, left} + {2'b00, right};
        diff = pos - {1'b0, neg};
        if ({1'b0, neg} > pos)
        begin
            res = '0;
        end
        else if (diff > 11'(CHAN_MAX))
        begin
            res = CHAN_W'(CHAN_MAX);
        end
        else
        begin
            res = diff[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/shp3_stream_if.sv
// Pixel input and sharpened result channel interfaces.
`default_nettype none
interface shp3_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_alpha;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output in_alpha, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input in_alpha, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

interface shp3_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_alpha;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] anchor_row;
    logic [10:0] anchor_col;
    logic        frame_last;

    modport source (output valid, output out_alpha, output out_red, output out_green,
                    output out_blue, output anchor_row, output anchor_col,
                    output frame_last, input ready);
    modport sink   (input valid, input out_alpha, input out_red, input out_green,
                    input out_blue, input anchor_row, input anchor_col,
                    input frame_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sharpen_3x3_window_filter_top.sv
// Top level of the 3x3 sharpen filter: counters, line store control and window.
//
// Takes one ARGB pixel per clock in raster order and gives one sharpened
// word per full 3x3 window, anchored at the window's top-left pixel; border
// anchors give nothing. An accepted pixel waits in the read stage while the
// line store read runs; the window shift and arithmetic follow when that
// stage advances, loading the output register for a word with a result. A new
// pixel is taken at every edge as long as the result side takes its words.
// The two previous rows live in one MAX_WIDTH-deep
// memory whose entries hold both rows of a column; each pixel reads its
// column once and writes it back when it leaves the read stage. The store
// needs no clearing after reset. Width is clamped to 3..MAX_WIDTH and
// height to at least 3; write the registers only while no frame is in flight.
`default_nettype none
module sharpen_3x3_window_filter_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [shp3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shp3_pkg::CFG_DATA_W-1:0]     cfg_data,
    shp3_pix_if.sink                            pix_in,
    shp3_res_if.source                          res_out
);
    import shp3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int LW  = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (LW > FW_REG_W) ? LW : FW_REG_W;
    localparam int DW  = (CW > ANCHOR_COL_W) ? CW : ANCHOR_COL_W;

    logic [FW_REG_W-1:0] frame_width_reg;
    logic [FH_REG_W-1:0] frame_height_reg;
    logic [CW-1:0]       col_count_reg;
    logic [ROW_W-1:0]    row_count_reg;

    logic [WW-1:0]       fw_ext;
    logic [WW-1:0]       w_eff;
    logic [CW-1:0]       w_last;
    logic [ROW_W-1:0]    h_last;
    logic                last_col;
    logic                last_row;
    logic [CW-1:0]       col_idx;
    logic [DW-1:0]       col_diff;
    logic                accept;
    ctrl_t               ctrl_next;

    logic                s1_valid_reg;
    ctrl_t               s1_ctrl_reg;
    pix_t                s1_px_reg;
    logic [CW-1:0]       s1_addr_reg;
    logic                s1_adv;
    logic                out_free;

    pix_t                new_px;
    line_pair_t          rd_data;
    line_pair_t          wr_data;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_REG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the frame size and locate the pixel
    always_comb
    begin
        fw_ext = WW'(frame_width_reg);
        if (fw_ext < WW'(MIN_DIM))
        begin
            w_eff = WW'(MIN_DIM);
        end
        else if (fw_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_ext;
        end
        w_last = CW'(w_eff - WW'(1));

        if (frame_height_reg < FH_REG_W'(MIN_DIM))
        begin
            h_last = ROW_W'(MIN_DIM - 1);
        end
        else
        begin
            h_last = frame_height_reg - ROW_W'(1);
        end

        last_col = (col_count_reg >= w_last);
        last_row = (row_count_reg >= h_last);
        col_idx  = last_col ? w_last : col_count_reg;
        col_diff = DW'(col_idx) - DW'(WIN_OFFSET);

        ctrl_next.emit = (row_count_reg >= ROW_W'(WIN_OFFSET))
                       && (col_idx >= CW'(WIN_OFFSET));
        ctrl_next.last = last_col && last_row;
        ctrl_next.row  = row_count_reg - ROW_W'(WIN_OFFSET);
        ctrl_next.col  = col_diff[ANCHOR_COL_W-1:0];
    end

    // Handshake: a word that gives no result never waits on the output
    assign s1_adv       = s1_valid_reg && (out_free || !s1_ctrl_reg.emit);
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign accept       = pix_in.valid && pix_in.ready;

    // Advance the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_count_reg <= '0;
                row_count_reg <= last_row ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    // Hold the pixel while its line store read is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= ctrl_next;
            s1_px_reg   <= new_px;
            s1_addr_reg <= col_idx;
        end
    end

    assign new_px.alpha = pix_in.in_alpha;
    assign new_px.red   = pix_in.in_red;
    assign new_px.green = pix_in.in_green;
    assign new_px.blue  = pix_in.in_blue;

    // Push the column down one row on write-back
    assign wr_data.top = rd_data.mid;
    assign wr_data.mid = s1_px_reg;

    shp3_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_idx),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    shp3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (s1_adv),
        .ctrl     (s1_ctrl_reg),
        .top_px   (rd_data.top),
        .mid_px   (rd_data.mid),
        .new_px   (s1_px_reg),
        .out_free (out_free),
        .res      (res_out)
    );

`ifndef SYNTHESIS
    // An accepted pixel always lands in the read stage
    a_accept_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not enter the read stage");

    // A pixel that makes no result never stalls
    a_no_emit_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ctrl_reg.emit) |-> s1_adv)
        else $error("non-emitting pixel stalled in the read stage");

    // A new result only comes from a window that advanced with emit set
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_out.valid) |-> $past(s1_adv && s1_ctrl_reg.emit))
        else $error("result appeared without an emitting window");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/shp3_line_buf.sv
// Two-row line store: one synchronous memory, one read and one write port.
`default_nettype none
module shp3_line_buf #(
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output shp3_pkg::line_pair_t     rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  shp3_pkg::line_pair_t     wr_data
);
    import shp3_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    // Write the shifted column back
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the column, hold the word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/shp3_window.sv
// 3x3 window taps, sharpen arithmetic and the result output register.
`default_nettype none
module shp3_window (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  shp3_pkg::ctrl_t ctrl,
    input  shp3_pkg::pix_t  top_px,
    input  shp3_pkg::pix_t  mid_px,
    input  shp3_pkg::pix_t  new_px,
    output logic            out_free,
    shp3_res_if.source      res
);
    import shp3_pkg::*;

    // Only the taps that feed the next result are kept
    pix_t win_t1_reg;
    pix_t win_t2_reg;
    pix_t win_m4_reg;
    pix_t win_m5_reg;
    pix_t win_b8_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    pix_t        out_px_reg;
    pix_t        out_px_next;
    logic [15:0] out_row_reg;
    logic [10:0] out_col_reg;
    logic        out_last_reg;

    // Shift the window left, new column enters on the right
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_t1_reg <= win_t2_reg;
            win_t2_reg <= top_px;
            win_m4_reg <= win_m5_reg;
            win_m5_reg <= mid_px;
            win_b8_reg <= new_px;
        end
    end

    // Sharpen the window as it stands after this shift
    always_comb
    begin
        out_px_next.alpha = win_t1_reg.alpha;
        out_px_next.red   = sharpen_chan(win_m5_reg.red, win_t2_reg.red, win_b8_reg.red,
                                         win_m4_reg.red, mid_px.red);
        out_px_next.green = sharpen_chan(win_m5_reg.green, win_t2_reg.green,
                                         win_b8_reg.green, win_m4_reg.green, mid_px.green);
        out_px_next.blue  = sharpen_chan(win_m5_reg.blue, win_t2_reg.blue, win_b8_reg.blue,
                                         win_m4_reg.blue, mid_px.blue);
    end

    assign out_free = !out_valid_reg || res.ready;

    // Load a new word or drop the taken one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (adv && ctrl.emit)
        begin
            out_px_reg   <= out_px_next;
            out_row_reg  <= ctrl.row;
            out_col_reg  <= ctrl.col;
            out_last_reg <= ctrl.last;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.out_alpha  = out_px_reg.alpha;
    assign res.out_red    = out_px_reg.red;
    assign res.out_green  = out_px_reg.green;
    assign res.out_blue   = out_px_reg.blue;
    assign res.anchor_row = out_row_reg;
    assign res.anchor_col = out_col_reg;
    assign res.frame_last = out_last_reg;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the 3x3 sharpen window filter top level.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import shp3_pkg::*;

    localparam int          MAX_COLS    = 2048;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_PIX  = 1150;

    // One sharpened word as it leaves the block
    typedef struct packed {
        logic [CHAN_W-1:0]       alpha;
        logic [CHAN_W-1:0]       red;
        logic [CHAN_W-1:0]       green;
        logic [CHAN_W-1:0]       blue;
        logic [ROW_W-1:0]        row;
        logic [ANCHOR_COL_W-1:0] col;
        logic                    last;
    } sharp_word_t;

    // Mirror of the filter state: registers, line store, window and counters,
    // plus the words that the accepted pixels still owe.
    class sharpen_tracker;
        logic [FW_REG_W-1:0]     fw_reg;
        logic [FH_REG_W-1:0]     fh_reg;
        pix_t                    upper_line [MAX_COLS];
        pix_t                    lower_line [MAX_COLS];
        bit                      upper_set  [MAX_COLS];
        bit                      lower_set  [MAX_COLS];
        pix_t                    win [9];
        logic [ROW_W-1:0]        row_cnt;
        logic [ANCHOR_COL_W-1:0] col_cnt;
        sharp_word_t             due_words [$];
        int unsigned             errors;

        function new();
            fw_reg  = FRAME_WIDTH_RST;
            fh_reg  = FRAME_HEIGHT_RST;
            row_cnt = '0;
            col_cnt = '0;
            errors  = 0;
            foreach (upper_set[i])
            begin
                upper_set[i] = 1'b0;
                lower_set[i] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FRAME_WIDTH)
            begin
                fw_reg = data[FW_REG_W-1:0];
            end
            else
            begin
                fh_reg = data[FH_REG_W-1:0];
            end
        endfunction

        // Width in use: register clamped to 3..MAX_COLS
        function int unsigned eff_width(logic [FW_REG_W-1:0] wreg);
            int unsigned w;
            w = wreg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > MAX_COLS) w = MAX_COLS;
            return w;
        endfunction

        // True when both rows of every column below the width hold written pixels
        function bit store_covers(logic [FW_REG_W-1:0] wreg);
            int unsigned w;
            w = eff_width(wreg);
            for (int unsigned c = 0; c < w; c++)
            begin
                if (!upper_set[c] || !lower_set[c]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit at_frame_start();
            return row_cnt == '0 && col_cnt == '0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // CENTER_GAIN * centre minus edge neighbours, clamped to the channel range
        function logic [CHAN_W-1:0] boost_chan(logic [CHAN_W-1:0] ctr, logic [CHAN_W-1:0] up,
                                               logic [CHAN_W-1:0] dn, logic [CHAN_W-1:0] lf,
                                               logic [CHAN_W-1:0] rt);
            int v;
            v = CENTER_GAIN * int'(ctr) - int'(up) - int'(dn) - int'(lf) - int'(rt);
            if (v < 0) v = 0;
            if (v > CHAN_MAX) v = CHAN_MAX;
            return CHAN_W'(v);
        endfunction

        // Advance the mirror by one accepted pixel and queue the word it completes
        function void take_pixel(pix_t px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            pix_t        top;
            pix_t        mid;
            bit          end_col;
            bit          end_row;
            sharp_word_t word;
            w = eff_width(fw_reg);
            h = fh_reg;
            if (h < MIN_DIM) h = MIN_DIM;
            c = col_cnt;
            r = row_cnt;
            // a stale column past a narrowed width lands on the last column
            if (c > w - 1) c = w - 1;

            top = upper_line[c];
            mid = lower_line[c];
            upper_line[c] = mid;
            upper_set[c]  = lower_set[c];
            lower_line[c] = px;
            lower_set[c]  = 1'b1;

            // shift the window left, new column on the right
            win[0] = win[1]; win[1] = win[2]; win[2] = top;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid;
            win[6] = win[7]; win[7] = win[8]; win[8] = px;

            end_col = col_cnt >= w - 1;
            end_row = row_cnt >= h - 1;

            if (r >= WIN_OFFSET && c >= WIN_OFFSET)
            begin
                word.alpha = win[0].alpha;
                word.red   = boost_chan(win[4].red, win[1].red, win[7].red,
                                        win[3].red, win[5].red);
                word.green = boost_chan(win[4].green, win[1].green, win[7].green,
                                        win[3].green, win[5].green);
                word.blue  = boost_chan(win[4].blue, win[1].blue, win[7].blue,
                                        win[3].blue, win[5].blue);
                word.row   = ROW_W'(r - WIN_OFFSET);
                word.col   = ANCHOR_COL_W'(c - WIN_OFFSET);
                word.last  = end_col && end_row;
                due_words.push_back(word);
            end

            if (end_col)
            begin
                col_cnt = '0;
                row_cnt = end_row ? '0 : row_cnt + 1'b1;
            end
            else
            begin
                col_cnt = col_cnt + 1'b1;
            end
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("[%0t] mismatch %s: want %h got %h", $time, what, want, got);
        endfunction

        function void compare(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want) report(what, want, got);
        endfunction

        // Match one delivered word against the oldest one owed
        function void check_word(sharp_word_t got);
            sharp_word_t want;
            if (due_words.size() == 0)
            begin
                report("word with nothing due, anchor_col", '0, 16'(got.col));
                return;
            end
            want = due_words.pop_front();
            compare("out_alpha",  16'(want.alpha), 16'(got.alpha));
            compare("out_red",    16'(want.red),   16'(got.red));
            compare("out_green",  16'(want.green), 16'(got.green));
            compare("out_blue",   16'(want.blue),  16'(got.blue));
            compare("anchor_row", want.row,        got.row);
            compare("anchor_col", 16'(want.col),   16'(got.col));
            compare("frame_last", 16'(want.last),  16'(got.last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    shp3_pix_if pix ();
    shp3_res_if res ();

    sharpen_tracker tracker;
    bit             idle_on;
    int unsigned    pixels_sent;

    sharpen_3x3_window_filter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix),
        .res_out   (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        for (int unsigned cycles = 0; cycles < CYCLE_LIMIT; cycles++)
        begin
            @(posedge clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    // Stall the result side in random bursts while idling is on
    initial
    begin
        int stall;
        stall = 0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                res.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 12) - 1;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
            end
        end
    end

    // Check every word the block hands over
    always @(posedge clk)
    begin : word_monitor
        sharp_word_t seen;
        if (rst_n && res.valid && res.ready)
        begin
            seen.alpha = res.out_alpha;
            seen.red   = res.out_red;
            seen.green = res.out_green;
            seen.blue  = res.out_blue;
            seen.row   = res.anchor_row;
            seen.col   = res.anchor_col;
            seen.last  = res.frame_last;
            tracker.check_word(seen);
        end
    end

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic pix_t rand_pixel();
        pix_t px;
        px.alpha = CHAN_W'($urandom);
        px.red   = rand_chan();
        px.green = rand_chan();
        px.blue  = rand_chan();
        return px;
    endfunction

    // Mostly small widths, some wider, some below range; upper bits are noise
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        logic [FW_REG_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = FW_REG_W'($urandom_range(0, 2));
            1, 2:    w = FW_REG_W'($urandom_range(11, 40));
            default: w = FW_REG_W'($urandom_range(3, 10));
        endcase
        return {4'($urandom), w};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'($urandom_range(0, 2));
            1, 2:    return CFG_DATA_W'($urandom_range(7, 12));
            default: return CFG_DATA_W'($urandom_range(3, 6));
        endcase
    endfunction

    // Offer one pixel, with an occasional gap first, and hold until taken
    task automatic send_pixel(input pix_t px);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        pix.valid    <= 1'b1;
        pix.in_alpha <= px.alpha;
        pix.in_red   <= px.red;
        pix.in_green <= px.green;
        pix.in_blue  <= px.blue;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        tracker.take_pixel(px);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Hold the input until every owed word is out, then let the pipe empty
    task automatic drain_results();
        pix.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write width then height while the block is idle
    task automatic write_frame_regs(input logic [CFG_DATA_W-1:0] w_data,
                                    input logic [CFG_DATA_W-1:0] h_data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w_data;
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h_data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.set_reg(REG_FRAME_WIDTH, w_data);
        tracker.set_reg(REG_FRAME_HEIGHT, h_data);
    endtask

    initial
    begin
        pix_t                  px;
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        int unsigned           rand_end;
        int unsigned           quiet_from;

        tracker      = new();
        idle_on      = 1'b1;
        pixels_sent  = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        pix.valid    = 1'b0;
        pix.in_alpha = '0;
        pix.in_red   = '0;
        pix.in_green = '0;
        pix.in_blue  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Smallest frame, centre at full scale: clamp high, one exact channel
        write_frame_regs(16'd3, 16'd3);
        for (int i = 0; i < 9; i++)
        begin
            px = '{alpha: 8'h11, red: 8'h00, green: 8'd20, blue: 8'h00};
            if (i == 0) px.alpha = 8'hFF;
            if (i == 4) px = '{alpha: 8'h00, red: 8'hFF, green: 8'd60, blue: 8'hFF};
            send_pixel(px);
        end

        // Width and height below range fall back to 3; neighbours at full scale
        // drive every channel to zero
        write_frame_regs(16'h0000, 16'h0002);
        for (int i = 0; i < 9; i++)
        begin
            px = '{alpha: 8'hFF, red: 8'hFF, green: 8'hFF, blue: 8'hFF};
            if (i == 0) px.alpha = 8'h00;
            if (i == 4) px = '{alpha: 8'hFF, red: 8'h00, green: 8'h00, blue: 8'h00};
            send_pixel(px);
        end

        // Tallest frame, then narrow and shorten it mid-frame so both counters wrap
        write_frame_regs(16'd8, 16'hFFFF);
        repeat (86) send_pixel(rand_pixel());
        write_frame_regs(16'd4, 16'd4);
        while (!tracker.at_frame_start()) send_pixel(rand_pixel());

        // Random frames with random settings, occasional mid-frame changes
        rand_end   = pixels_sent + RANDOM_PIX;
        quiet_from = pixels_sent + RANDOM_PIX * 4 / 5;
        while (pixels_sent < rand_end)
        begin
            if (pixels_sent >= quiet_from)
            begin
                idle_on = 1'b0;
            end
            else if ($urandom_range(0, 149) == 0)
            begin
                idle_on = !idle_on;
            end

            if (tracker.at_frame_start() && $urandom_range(0, 2) == 0)
            begin
                write_frame_regs(pick_width(), pick_height());
            end
            else if ($urandom_range(0, 149) == 0)
            begin
                wd = pick_width();
                hd = pick_height();
                // change mid-frame only over columns the store already holds
                if (tracker.store_covers(wd[FW_REG_W-1:0])) write_frame_regs(wd, hd);
            end
            else if ($urandom_range(0, 299) == 0)
            begin
                drain_results();
            end
            send_pixel(rand_pixel());
        end

        idle_on = 1'b0;
        drain_results();
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
